FILE: sv/plr_pkg.sv
package plr_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_SET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } plr_cmd_t;

    localparam logic signed [VAL_W-1:0] READ_FAIL = -32'sd1;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } plr_req_t;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        count;
        logic                    empty_res;
    } plr_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic ins;
        logic rem;
        logic set;
        logic clr;
        logic get;
        logic ok;
    } plr_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } plr_stat_t;

endpackage

FILE: sv/plr_ctrl.sv
module plr_ctrl
    import plr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  plr_req_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  plr_stat_t stat,
    output plr_ctl_t  ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             in_list;
    logic             ins_ok;
    logic             full;
    logic             take;

    assign rsp_valid = (state_reg == ST_HOLD);
    assign req_ready = (state_reg == ST_IDLE) || rsp_ready;
    assign take      = req_valid && req_ready;

    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(stat.count);
    assign full    = (stat.count == CNT_W'(CAPACITY));
    assign in_list = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1)) && !full;

    always_comb
    begin
        ctl      = '0;
        ctl.load = take;
        unique case (req.cmd)
            CMD_INSERT:
            begin
                ctl.ins = take && ins_ok;
                ctl.ok  = ins_ok;
            end
            CMD_REMOVE:
            begin
                ctl.rem = take && in_list;
                ctl.ok  = in_list;
            end
            CMD_GET:
            begin
                ctl.get = 1'b1;
                ctl.ok  = in_list;
            end
            CMD_SET:
            begin
                ctl.set = take && in_list;
                ctl.ok  = in_list;
            end
            CMD_CLEAR:
            begin
                ctl.clr = take;
                ctl.ok  = 1'b1;
            end
            default:
            begin
                ctl.ok  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (take)
            state_next = ST_HOLD;
        else if (rsp_ready)
            state_next = ST_IDLE;
        else
            state_next = state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/plr_dp.sv
module plr_dp
    import plr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  plr_req_t  req,
    input  plr_ctl_t  ctl,
    output plr_stat_t stat,
    output plr_rsp_t  rsp
);

    logic signed [VAL_W-1:0] entries_reg [CAPACITY];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    plr_rsp_t                rsp_reg;
    plr_rsp_t                rsp_next;
    logic [POS_W-1:0]        pos_m1;
    logic [IDX_W-1:0]        idx;

    assign pos_m1 = req.position - POS_W'(1);
    assign idx    = pos_m1[IDX_W-1:0];

    // shift cells: each entry looks only at its neighbors
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ctl.ins)
            begin
                if (IDX_W'(i) == idx)
                    entries_reg[i] <= req.value;
                else if ((i > 0) && (IDX_W'(i) > idx))
                    entries_reg[i] <= entries_reg[(i > 0) ? i - 1 : 0];
            end
            else if (ctl.rem)
            begin
                if ((i < CAPACITY - 1) && (IDX_W'(i) >= idx))
                    entries_reg[i] <= entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
            else if (ctl.set && (IDX_W'(i) == idx))
            begin
                entries_reg[i] <= req.value;
            end
        end
    end

    always_comb
    begin
        priority if (ctl.clr)
            count_next = '0;
        else if (ctl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctl.rem)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_comb
    begin
        rsp_next.ok         = ctl.ok;
        rsp_next.read_value = '0;
        if (ctl.get)
            rsp_next.read_value = ctl.ok ? entries_reg[idx] : READ_FAIL;
        rsp_next.count      = count_next;
        rsp_next.empty_res  = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            rsp_reg <= rsp_next;
    end

    assign stat.count = count_reg;
    assign rsp        = rsp_reg;

endmodule

FILE: sv/positional_list_insert_remove_unit.sv
// A result is valid in the cycle after its request transaction is taken.
// Throughput: one transaction per cycle while rsp_ready accepts each response; every
// command, including insert and remove, is handled in a single step because all cells shift in parallel.
// The response register is taken over in the same cycle it is consumed.
// Reset (rst_n low, asynchronous): list count zero, no response pending;
// entry contents are not cleared.
module positional_list_insert_remove_unit
    import plr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  plr_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output plr_rsp_t rsp
);

    plr_ctl_t  ctl;
    plr_stat_t stat;

    plr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    plr_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctl   (ctl),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

FILE: sv/plr_checker.sv
module plr_checker
    import plr_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input plr_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input plr_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no response after accepted transaction");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.empty_res == (rsp.count == '0)) &&
                      (rsp.count <= CNT_W'(CAPACITY)))
        else $error("count or empty flag inconsistent");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.cmd == CMD_CLEAR)
        |=> rsp.ok && (rsp.count == '0) && (rsp.read_value == '0))
        else $error("clear response wrong");

endmodule

bind positional_list_insert_remove_unit plr_checker u_plr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

FILE: test/tb_positional_list_insert_remove_unit.sv
`default_nettype none

module tb_positional_list_insert_remove_unit;
    import plr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int RANDOM_ITEMS   = 500;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    plr_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    plr_rsp_t rsp;

    positional_list_insert_remove_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    // list model
    logic signed [VAL_W-1:0] list_mem [CAPACITY];
    int                      list_count;
    plr_rsp_t                pending_rsp [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int fail_count;
    int cmd_seen [8];
    int ok_seen;
    int full_rejects;
    int rsp_checked;
    int stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic plr_rsp_t predict_list_op(input plr_req_t item);
        plr_rsp_t r;
        int       p;
        bit       hit;
        p   = item.position;
        hit = (p >= 1) && (p <= list_count);
        r   = '0;
        case (item.cmd)
            CMD_INSERT:
            begin
                if (p >= 1 && p <= list_count + 1 && list_count < CAPACITY)
                begin
                    for (int i = list_count; i >= p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = item.value;
                    list_count++;
                    r.ok = 1'b1;
                end
                else if (list_count == CAPACITY)
                    full_rejects++;
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = p; i < list_count; i++)
                        list_mem[i-1] = list_mem[i];
                    list_count--;
                    r.ok = 1'b1;
                end
            end
            CMD_GET:
            begin
                if (hit)
                begin
                    r.read_value = list_mem[p-1];
                    r.ok         = 1'b1;
                end
                else
                    r.read_value = READ_FAIL;
            end
            CMD_SET:
            begin
                if (hit)
                begin
                    list_mem[p-1] = item.value;
                    r.ok          = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                list_count = 0;
                r.ok       = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count     = list_count[CNT_W-1:0];
        r.empty_res = (list_count == 0);
        return r;
    endfunction

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_list_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val);
        plr_req_t item;
        plr_rsp_t exp_rsp;
        bit       fire;
        item.cmd      = cmd;
        item.position = pos;
        item.value    = val;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
        begin
            @(negedge clk);
            fire = req_ready;
            @(posedge clk);
        end
        while (!fire);
        exp_rsp = predict_list_op(item);
        pending_rsp.push_back(exp_rsp);
        cmd_seen[cmd]++;
        if (exp_rsp.ok)
            ok_seen++;
    endtask

    task automatic wait_list_drained();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic plr_req_t random_list_op();
        plr_req_t item;
        int       roll;
        int       top;
        roll = $urandom_range(99);
        if (roll < 32)
            item.cmd = CMD_INSERT;
        else if (roll < 52)
            item.cmd = CMD_REMOVE;
        else if (roll < 70)
            item.cmd = CMD_GET;
        else if (roll < 86)
            item.cmd = CMD_SET;
        else if (roll < 89)
            item.cmd = CMD_CLEAR;
        else if (roll < 92)
            item.cmd = CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
        else
            item.cmd = CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_INSERT));
        top = (item.cmd == CMD_INSERT) ? list_count + 1 : list_count;
        if (top < 1)
            top = 1;
        if ($urandom_range(9) < 8)
            item.position = POS_W'($urandom_range(top, 1));
        else
            item.position = POS_W'($urandom_range(31, 0));
        case ($urandom_range(15))
            0:       item.value = 32'h8000_0000;
            1:       item.value = 32'h7fff_ffff;
            2:       item.value = '0;
            3:       item.value = '1;
            default: item.value = $urandom();
        endcase
        return item;
    endfunction

    task automatic test_edges_on_small_list();
        send_list_op(CMD_GET,    5'd1,  32'sd7);
        send_list_op(CMD_REMOVE, 5'd1,  32'sd0);
        send_list_op(CMD_SET,    5'd1,  32'sd9);
        send_list_op(CMD_INSERT, 5'd0,  32'sd1);
        send_list_op(CMD_INSERT, 5'd2,  32'sd2);
        send_list_op(CMD_INSERT, 5'd1,  32'h7fff_ffff);
        send_list_op(CMD_INSERT, 5'd1,  32'h8000_0000);
        send_list_op(CMD_INSERT, 5'd3,  -32'sd1);
        send_list_op(CMD_INSERT, 5'd2,  32'sd0);
        send_list_op(CMD_GET,    5'd0,  32'sd0);
        send_list_op(CMD_GET,    5'd4,  32'sd0);
        send_list_op(CMD_GET,    5'd5,  32'sd0);
        send_list_op(CMD_SET,    5'd4,  32'h5a5a_a5a5);
        send_list_op(CMD_SET,    5'd5,  32'sd3);
        send_list_op(CMD_REMOVE, 5'd5,  32'sd0);
        send_list_op(CMD_REMOVE, 5'd1,  32'sd0);
        send_list_op(CMD_GET,    5'd1,  32'sd0);
        send_list_op(CMD_RSVD_FIRST, 5'd1, 32'sd4);
        send_list_op(CMD_RSVD_MID,   5'd2, 32'sd5);
        send_list_op(CMD_RSVD_LAST,  5'd31, '1);
        send_list_op(CMD_REMOVE, 5'd3,  32'sd0);
        send_list_op(CMD_CLEAR,  5'd0,  32'sd0);
        send_list_op(CMD_CLEAR,  5'd31, '1);
        send_list_op(CMD_GET,    5'd31, 32'sd0);
    endtask

    // receiver held off at the start, then the list is filled past capacity
    task automatic test_fill_under_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_list_op(CMD_CLEAR, 5'd0, 32'sd0);
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < CAPACITY + 2; i++)
            send_list_op(CMD_INSERT, POS_W'(list_count + 1), $urandom());
        send_list_op(CMD_INSERT, 5'd1, 32'sd11);
        send_list_op(CMD_GET, 5'd16, 32'sd0);
        send_list_op(CMD_GET, 5'd17, 32'sd0);
        wait_list_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        plr_req_t item;
        int       sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            item = random_list_op();
            send_list_op(item.cmd, item.position, item.value);
            if (item.cmd <= CMD_CLEAR)
                sent++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // response checker
    initial
    begin
        plr_rsp_t got;
        plr_rsp_t exp_rsp;
        bit       take;
        forever
        begin
            @(negedge clk);
            take = rsp_valid && rsp_ready && rst_n;
            got  = rsp;
            @(posedge clk);
            if (take)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("response transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    rsp_checked++;
                    if (got.ok !== exp_rsp.ok)
                    begin
                        $error("ok mismatch: expected %0d, got %0d", exp_rsp.ok, got.ok);
                        fail_count++;
                    end
                    if (got.read_value !== exp_rsp.read_value)
                    begin
                        $error("read_value mismatch: expected %0d, got %0d",
                               exp_rsp.read_value, got.read_value);
                        fail_count++;
                    end
                    if (got.count !== exp_rsp.count)
                    begin
                        $error("count mismatch: expected %0d, got %0d",
                               exp_rsp.count, got.count);
                        fail_count++;
                    end
                    if (got.empty_res !== exp_rsp.empty_res)
                    begin
                        $error("empty_res mismatch: expected %0d, got %0d",
                               exp_rsp.empty_res, got.empty_res);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        list_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        fail_count     = 0;
        ok_seen        = 0;
        full_rejects   = 0;
        rsp_checked    = 0;
        stall_cycles   = 0;
        foreach (cmd_seen[i])
            cmd_seen[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edges_on_small_list();
        test_fill_under_backpressure();
        test_random_phase(0, 0);
        test_random_phase(46, 0);
        test_random_phase(0, 46);
        test_random_phase(16, 16);
        wait_list_drained();

        $display("checked %0d responses: insert %0d, remove %0d, get %0d, set %0d, clear %0d",
                 rsp_checked, cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE], cmd_seen[CMD_GET],
                 cmd_seen[CMD_SET], cmd_seen[CMD_CLEAR]);
        $display("ignored codes %0d, successful ops %0d, inserts refused on full list %0d",
                 cmd_seen[CMD_RSVD_FIRST] + cmd_seen[CMD_RSVD_MID] + cmd_seen[CMD_RSVD_LAST],
                 ok_seen, full_rejects);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
